// ===== rtl/core/mexp_pkg.sv =====
// shared types, widths and state codes for the modular exponentiation block
package mexp_pkg;

  // operand widths actually used by the datapath
  localparam int EXP_BITS = 63;
  localparam int MOD_BITS = 31;

  // fixed payload widths of the channels
  localparam int BASE_W = 31;
  localparam int EXP_W  = 63;
  localparam int MODV_W = 31;
  localparam int OUT_W  = 31;

  // step counter of the modular multiplier
  localparam int CNT_W = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

  typedef logic [MOD_BITS-1:0] opd_t;
  typedef logic [EXP_BITS-1:0] exp_t;

  // request into the shared modular multiplier
  typedef struct packed {
    logic start;
    opd_t a;
    opd_t b;
    opd_t m;
  } mm_req_t;

  // answer from the shared modular multiplier
  typedef struct packed {
    logic done;
    opd_t result;
  } mm_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEXT,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/mexp_if.sv =====
// valid/ready channel interfaces for operands and results
interface mexp_in_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base_value;
  logic [EXP_W-1:0]  exponent_value;
  logic [MODV_W-1:0] modulus_value;

  modport source (output valid, output base_value, output exponent_value,
                  output modulus_value, input ready);
  modport sink (input valid, input base_value, input exponent_value,
                input modulus_value, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

// ===== rtl/core/mexp_mulmod.sv =====
// interleaved shift-and-add modular multiplier, one multiplier bit per cycle
module mexp_mulmod import mexp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  opd_t             a_r;
  opd_t             b_r;
  opd_t             m_r;
  opd_t             r_r;
  opd_t             r_nxt;

  logic [MOD_BITS+1:0] sum;
  logic [MOD_BITS+1:0] m1;
  logic [MOD_BITS+1:0] m2;
  opd_t                addend;

  // r <- (2r + bit*a) mod m; sum stays below 3m, so subtract m or 2m
  always_comb begin
    addend = b_r[MOD_BITS-1] ? a_r : '0;
    sum    = {1'b0, r_r, 1'b0} + {2'b00, addend};
    m1     = {2'b00, m_r};
    m2     = {1'b0, m_r, 1'b0};
    priority if (sum >= m2) begin
      r_nxt = MOD_BITS'(sum - m2);
    end else if (sum >= m1) begin
      r_nxt = MOD_BITS'(sum - m1);
    end else begin
      r_nxt = MOD_BITS'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      m_r   <= req.m;
      r_r   <= '0;
      cnt_r <= CNT_W'(MOD_BITS - 1);
    end else if (busy_r) begin
      r_r   <= r_nxt;
      b_r   <= b_r << 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = r_r;

  // partial remainder stays reduced throughout the scan
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start |-> r_r < m_r)
    else $error("partial remainder not reduced");

  // done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");

  // no new request while a product is still in progress
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("multiplier restarted while busy");

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// modular exponentiation top: right-to-left square-and-multiply over a shared mulmod
// sequence: reduce the base first, then per exponent bit up to the highest set one:
//   a decision, a multiply if the bit is set and a square, then a last decision
//   and a load of the result into the output register
// throughput: one beat at a time, in_chan.ready only while idle; set by the mulmod unit
// zero exponent or zero modulus skip the mulmod; reset (sync, active low) clears fsm
module modular_exponentiation import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mexp_in_if.sink    in_chan,
  mexp_out_if.source out_chan
);

  state_t state_r, state_nxt;

  // running exponent, shifted right as bits are consumed
  exp_t e_r, e_nxt;
  // modulus, accumulator and current square
  opd_t m_r, m_nxt;
  opd_t acc_r, acc_nxt;
  opd_t sq_r, sq_nxt;

  // output register decouples the result beat from the sequencer
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] res_r, res_nxt;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  exp_t in_exp;
  opd_t in_base;
  opd_t in_mod;

  // bits above the configured widths are ignored
  assign in_exp  = in_chan.exponent_value[EXP_BITS-1:0];
  assign in_base = in_chan.base_value[MOD_BITS-1:0];
  assign in_mod  = in_chan.modulus_value[MOD_BITS-1:0];

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    mm_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          e_nxt   = in_exp;
          m_nxt   = in_mod;
          acc_nxt = MOD_BITS'(1);
          if (in_exp == '0) begin
            // zero exponent answers one for any modulus
            state_nxt = ST_FINISH;
          end else if (in_mod == '0) begin
            // no reduction defined, answer zero
            acc_nxt   = '0;
            state_nxt = ST_FINISH;
          end else begin
            // first pass reduces the base: 1 * base mod m
            mm_req.start = 1'b1;
            mm_req.a     = MOD_BITS'(1);
            mm_req.b     = in_base;
            mm_req.m     = in_mod;
            state_nxt    = ST_REDUCE;
          end
        end
      end

      ST_REDUCE: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          state_nxt = ST_NEXT;
        end
      end

      ST_NEXT: begin
        priority if (e_r == '0) begin
          // no set bits left, accumulator is final
          state_nxt = ST_FINISH;
        end else if (e_r[0]) begin
          mm_req.start = 1'b1;
          mm_req.a     = acc_r;
          mm_req.b     = sq_r;
          mm_req.m     = m_r;
          state_nxt    = ST_MUL;
        end else begin
          mm_req.start = 1'b1;
          mm_req.a     = sq_r;
          mm_req.b     = sq_r;
          mm_req.m     = m_r;
          state_nxt    = ST_SQR;
        end
      end

      ST_MUL: begin
        if (mm_rsp.done) begin
          // fold in the square, then square right away
          acc_nxt      = mm_rsp.result;
          mm_req.start = 1'b1;
          mm_req.a     = sq_r;
          mm_req.b     = sq_r;
          mm_req.m     = m_r;
          state_nxt    = ST_SQR;
        end
      end

      ST_SQR: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          e_nxt     = e_r >> 1;
          state_nxt = ST_NEXT;
        end
      end

      ST_FINISH: begin
        // wait until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          res_nxt       = OUT_W'(acc_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    res_r <= res_nxt;
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.power_result = res_r;

  // multiplier answers only arrive while the sequencer waits for one
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == ST_REDUCE || state_r == ST_MUL || state_r == ST_SQR))
    else $error("unexpected multiplier completion");

  // operands stay reduced between exponent bits
  a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NEXT |-> (sq_r < m_r) && ((acc_r < m_r) || (acc_r == MOD_BITS'(1))))
    else $error("operand not reduced modulo m");

  // a result beat is loaded only when the register is free
  a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH && out_valid_r && !out_chan.ready |=> state_r == ST_FINISH)
    else $error("result left finish while output blocked");

endmodule
